@@ sv/ggc_pkg.sv @@
package ggc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VERT_W       = $clog2(MAX_VERTICES);
  localparam int COLOR_W      = 6;
  localparam int NUM_COLORS   = 1 << COLOR_W;
  localparam int MEX_W        = COLOR_W + 1;
  localparam int USED_W       = 7;

  typedef enum logic [1:0] {
    OP_CLEAR_COLORS = 2'd0,
    OP_ADD_NEIGHBOR = 2'd1,
    OP_COLOR        = 2'd2,
    OP_CLEAR_GRAPH  = 2'd3
  } op_t;

  typedef struct packed {
    logic capture;   // latch the accepted item
    logic dispatch;  // adjacency row is ready: execute the operation
    logic walk;      // issue one vertex color read
    logic finish;    // pick the lowest free color and commit it
    logic load_out;  // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic walk_last;
  } dp_status_t;

  // Lowest clear bit of the taken-color mask; NUM_COLORS when all are taken.
  function automatic logic [MEX_W-1:0] lowest_free(input logic [NUM_COLORS-1:0] taken);
    logic [MEX_W-1:0] r;
    r = MEX_W'(NUM_COLORS);
    for (int i = NUM_COLORS - 1; i >= 0; i--) begin
      if (!taken[i]) r = MEX_W'(i);
    end
    return r;
  endfunction

endpackage

@@ sv/greedy_graph_coloring_top.sv @@
// Greedy graph coloring engine over an adjacency matrix of up to 64 vertices.
// Input channel (in_valid/in_ready) carries one item: operation, vertex and
// neighbor. Operations: clear colorings, add a neighbor entry, color the next
// vertex, clear the graph. Every item produces exactly one result on the
// output channel (out_valid/out_ready): color and colors_used.
// A color item walks all 64 entries of the vertex color memory through its
// single read port, one entry per cycle, to collect the colors held by
// colored neighbors. One item is in progress at a time: the next item is
// not taken until the current one has reached the output register.
// The result sits in an output register: a new item is taken while it still
// waits, but if the receiver stalls, the next result holds inside the block
// and no further item is accepted until the register frees up.
// Reset (rst, synchronous) empties the graph and the colorings; clearing the
// graph resets the row valid bits, with no sweep of the adjacency memory.
module greedy_graph_coloring_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   operation,
  input  logic [ggc_pkg::VERT_W-1:0]   vertex,
  input  logic [ggc_pkg::VERT_W-1:0]   neighbor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ggc_pkg::COLOR_W-1:0]  color,
  output logic [ggc_pkg::USED_W-1:0]   colors_used
);

  ggc_pkg::ctrl_cmd_t  cmd;
  ggc_pkg::dp_status_t status;

  ggc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ggc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .operation  (operation),
    .vertex     (vertex),
    .neighbor   (neighbor),
    .color      (color),
    .colors_used(colors_used)
  );

endmodule

@@ sv/ggc_ram.sv @@
module ggc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ggc_datapath.sv @@
module ggc_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  ggc_pkg::ctrl_cmd_t         cmd,
  output ggc_pkg::dp_status_t        status,
  input  logic [1:0]                 operation,
  input  logic [ggc_pkg::VERT_W-1:0] vertex,
  input  logic [ggc_pkg::VERT_W-1:0] neighbor,
  output logic [ggc_pkg::COLOR_W-1:0] color,
  output logic [ggc_pkg::USED_W-1:0] colors_used
);

  ggc_pkg::op_t                        op_q;
  logic [ggc_pkg::VERT_W-1:0]          v_q;
  logic [ggc_pkg::VERT_W-1:0]          nb_q;
  logic [ggc_pkg::MAX_VERTICES-1:0]    adj_valid;
  logic [ggc_pkg::MAX_VERTICES-1:0]    colored_mask;
  logic [ggc_pkg::USED_W-1:0]          highest;
  logic [ggc_pkg::MAX_VERTICES-1:0]    cand;
  logic [ggc_pkg::NUM_COLORS-1:0]      taken;
  logic [ggc_pkg::VERT_W-1:0]          idx;
  logic                                p_valid;
  logic [ggc_pkg::VERT_W-1:0]          p_idx;
  logic [ggc_pkg::COLOR_W-1:0]         res_color;

  logic [ggc_pkg::MAX_VERTICES-1:0]    adj_rdata;
  logic [ggc_pkg::MAX_VERTICES-1:0]    row;
  logic [ggc_pkg::MAX_VERTICES-1:0]    nb_bit;
  logic                                adj_we;
  logic [ggc_pkg::COLOR_W-1:0]         color_rdata;
  logic [ggc_pkg::MEX_W-1:0]           mex;
  logic [ggc_pkg::USED_W-1:0]          used_new;
  logic [ggc_pkg::COLOR_W-1:0]         mex_sat;

  // A row never written since the last graph clear reads as empty.
  assign row    = adj_valid[v_q] ? adj_rdata : '0;
  assign adj_we = cmd.dispatch && (op_q == ggc_pkg::OP_ADD_NEIGHBOR);

  always_comb begin
    nb_bit       = '0;
    nb_bit[nb_q] = 1'b1;
  end

  assign mex      = ggc_pkg::lowest_free(taken);
  assign used_new = ggc_pkg::USED_W'(mex) + ggc_pkg::USED_W'(1);
  assign mex_sat  = mex[ggc_pkg::COLOR_W] ? {ggc_pkg::COLOR_W{1'b1}}
                                          : mex[ggc_pkg::COLOR_W-1:0];

  assign status.op        = op_q;
  assign status.walk_last = (idx == ggc_pkg::VERT_W'(ggc_pkg::MAX_VERTICES - 1));

  ggc_ram #(
    .WIDTH(ggc_pkg::MAX_VERTICES),
    .DEPTH(ggc_pkg::MAX_VERTICES)
  ) u_adj_ram (
    .clk  (clk),
    .we   (adj_we),
    .waddr(v_q),
    .wdata(row | nb_bit),
    .raddr(v_q),
    .rdata(adj_rdata)
  );

  ggc_ram #(
    .WIDTH(ggc_pkg::COLOR_W),
    .DEPTH(ggc_pkg::MAX_VERTICES)
  ) u_color_ram (
    .clk  (clk),
    .we   (cmd.finish),
    .waddr(v_q),
    .wdata(mex_sat),
    .raddr(idx),
    .rdata(color_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_valid    <= '0;
      colored_mask <= '0;
      highest      <= '0;
      p_valid      <= 1'b0;
    end else begin
      if (cmd.capture) begin
        op_q <= ggc_pkg::op_t'(operation);
        v_q  <= vertex;
        nb_q <= neighbor;
      end

      if (cmd.dispatch) begin
        res_color <= '0;
        case (op_q)
          ggc_pkg::OP_CLEAR_COLORS: begin
            colored_mask <= '0;
            highest      <= '0;
          end
          ggc_pkg::OP_ADD_NEIGHBOR: adj_valid[v_q] <= 1'b1;
          ggc_pkg::OP_COLOR: begin
            cand  <= row & colored_mask;
            taken <= '0;
            idx   <= '0;
          end
          default: adj_valid <= '0;
        endcase
      end

      // Color read data is registered and comes back in the cycle after issue; p_idx tracks the vertex.
      p_valid <= cmd.walk;
      if (cmd.walk) begin
        idx   <= idx + ggc_pkg::VERT_W'(1);
        p_idx <= idx;
      end
      if (p_valid && cand[p_idx]) taken[color_rdata] <= 1'b1;

      if (cmd.finish) begin
        colored_mask[v_q] <= 1'b1;
        res_color         <= mex_sat;
        if (used_new > highest) highest <= used_new;
      end

      if (cmd.load_out) begin
        color       <= res_color;
        colors_used <= highest;
      end
    end
  end

endmodule

@@ sv/ggc_ctrl.sv @@
module ggc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ggc_pkg::dp_status_t status,
  output ggc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DISPATCH,
    S_WALK,
    S_DRAIN,
    S_MEX,
    S_DONE
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.dispatch = (state == S_DISPATCH);
    cmd.walk     = (state == S_WALK);
    cmd.finish   = (state == S_MEX);
    cmd.load_out = (state == S_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:     if (in_valid) state <= S_READ;
        S_READ:     state <= S_DISPATCH;
        S_DISPATCH: state <= (status.op == ggc_pkg::OP_COLOR) ? S_WALK : S_DONE;
        S_WALK:     if (status.walk_last) state <= S_DRAIN;
        S_DRAIN:    state <= S_MEX;
        S_MEX:      state <= S_DONE;
        S_DONE: begin
          // Hold the result until the output register frees up.
          if (cmd.load_out) state <= S_IDLE;
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/ggc_checker.sv @@
module ggc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ggc_pkg::COLOR_W-1:0]  color,
  input logic [ggc_pkg::USED_W-1:0]   colors_used
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color) && $stable(colors_used))
    else $error("output item changed while stalled");

  // One item at a time: acceptance drops ready for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // A nonzero color is always counted by colors_used.
  a_color_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (color == '0) || (ggc_pkg::USED_W'(color) < colors_used))
    else $error("color outside colors_used");

  // No result appears in the cycle after an item is taken from idle.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind greedy_graph_coloring_top ggc_checker u_ggc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .color      (color),
  .colors_used(colors_used)
);

@@ test/greedy_graph_coloring_checker.sv @@
`timescale 1ns / 1ps

module greedy_graph_coloring_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [ggc_pkg::VERT_W-1:0]  vertex,
  input  logic [ggc_pkg::VERT_W-1:0]  neighbor,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [ggc_pkg::COLOR_W-1:0] color,
  input  logic [ggc_pkg::USED_W-1:0]  colors_used,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic [ggc_pkg::COLOR_W-1:0] color;
    logic [ggc_pkg::USED_W-1:0]  used;
  } coloring_t;

  logic [ggc_pkg::MAX_VERTICES-1:0] adj_rows [ggc_pkg::MAX_VERTICES];
  logic [ggc_pkg::COLOR_W-1:0]      held_color [ggc_pkg::MAX_VERTICES];
  logic [ggc_pkg::MAX_VERTICES-1:0] colored;
  logic [ggc_pkg::USED_W-1:0]       used_count;

  coloring_t coloring_queue[$];
  int        mismatches = 0;
  int        queued_cnt = 0;

  assign errors  = mismatches;
  assign pending = queued_cnt;

  task automatic clear_graph_state();
    foreach (adj_rows[i]) adj_rows[i] = '0;
    foreach (held_color[i]) held_color[i] = '0;
    colored    = '0;
    used_count = '0;
  endtask

  // Apply one item to the local copy of the graph and return the coloring it reports.
  function automatic coloring_t predict_coloring(input ggc_pkg::op_t op,
                                                 input logic [ggc_pkg::VERT_W-1:0] v,
                                                 input logic [ggc_pkg::VERT_W-1:0] nb);
    coloring_t                      res;
    logic [ggc_pkg::NUM_COLORS-1:0] taken;
    int                             mex;
    res = '0;
    case (op)
      ggc_pkg::OP_CLEAR_COLORS: begin
        colored    = '0;
        used_count = '0;
      end
      ggc_pkg::OP_ADD_NEIGHBOR: begin
        adj_rows[v][nb] = 1'b1;
      end
      ggc_pkg::OP_COLOR: begin
        taken = '0;
        for (int u = 0; u < ggc_pkg::MAX_VERTICES; u++) begin
          if (adj_rows[v][u] && colored[u]) taken[held_color[u]] = 1'b1;
        end
        mex = 0;
        while (mex < ggc_pkg::NUM_COLORS && taken[mex]) mex++;
        // every color taken: report the top color; colors_used counts one past all of them
        if (mex + 1 > used_count) used_count = ggc_pkg::USED_W'(mex + 1);
        if (mex > ggc_pkg::NUM_COLORS - 1) mex = ggc_pkg::NUM_COLORS - 1;
        held_color[v] = ggc_pkg::COLOR_W'(mex);
        colored[v]    = 1'b1;
        res.color     = ggc_pkg::COLOR_W'(mex);
      end
      default: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
    endcase
    res.used = used_count;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    coloring_t want;
    if (rst) begin
      clear_graph_state();
      coloring_queue.delete();
      queued_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (coloring_queue.size() == 0) begin
          report_mismatch("result with no item waiting", color, -1);
        end else begin
          want = coloring_queue.pop_front();
          if (color !== want.color) report_mismatch("color", color, want.color);
          if (colors_used !== want.used) report_mismatch("colors_used", colors_used, want.used);
        end
      end
      if (in_valid && in_ready) begin
        coloring_queue = {coloring_queue,
                          predict_coloring(ggc_pkg::op_t'(operation), vertex, neighbor)};
      end
      queued_cnt <= coloring_queue.size();
    end
  end

endmodule

@@ test/greedy_graph_coloring_top_tb.sv @@
`timescale 1ns / 1ps

module greedy_graph_coloring_top_tb;

  localparam int LONG_HOLD  = 400;
  localparam int MAX_GAP    = 40;
  localparam int DRAIN_CYC  = 80;
  localparam int LADDER_LEN = 32;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  operation = 2'd0;
  logic [ggc_pkg::VERT_W-1:0]  vertex = '0;
  logic [ggc_pkg::VERT_W-1:0]  neighbor = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [ggc_pkg::COLOR_W-1:0] color;
  logic [ggc_pkg::USED_W-1:0]  colors_used;

  int errors;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_seen = 0;
  int hold_left = 0;
  int items_sent = 0;

  greedy_graph_coloring_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .vertex      (vertex),
    .neighbor    (neighbor),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .color       (color),
    .colors_used (colors_used)
  );

  greedy_graph_coloring_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .vertex      (vertex),
    .neighbor    (neighbor),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .color       (color),
    .colors_used (colors_used),
    .errors      (errors),
    .pending     (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holds_seen != holds_asked) begin
      holds_seen <= holds_seen + 1;
      hold_left  <= LONG_HOLD;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [ggc_pkg::VERT_W-1:0] rand_vertex();
    return ggc_pkg::VERT_W'($urandom_range(ggc_pkg::MAX_VERTICES - 1));
  endfunction

  // Offer one item and return in the step where it is accepted; valid stays up.
  task automatic send_item(input ggc_pkg::op_t op, input logic [ggc_pkg::VERT_W-1:0] v,
                           input logic [ggc_pkg::VERT_W-1:0] nb);
    int gaps;
    gaps = 0;
    while (gaps < MAX_GAP && $urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    vertex    <= v;
    neighbor  <= nb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_directed();
    send_item(ggc_pkg::OP_CLEAR_COLORS, 6'd0, 6'd63);
    send_item(ggc_pkg::OP_COLOR, 6'd0, 6'd0);
    send_item(ggc_pkg::OP_ADD_NEIGHBOR, 6'd0, 6'd0);
    send_item(ggc_pkg::OP_ADD_NEIGHBOR, 6'd0, 6'd0);
    // recolor with a self entry: the old color counts as taken
    send_item(ggc_pkg::OP_COLOR, 6'd0, 6'd63);
    send_item(ggc_pkg::OP_ADD_NEIGHBOR, 6'd63, 6'd0);
    send_item(ggc_pkg::OP_ADD_NEIGHBOR, 6'd63, 6'd63);
    send_item(ggc_pkg::OP_COLOR, 6'd63, 6'd0);
    send_item(ggc_pkg::OP_ADD_NEIGHBOR, 6'd0, 6'd63);
    send_item(ggc_pkg::OP_COLOR, 6'd0, 6'd0);
    send_item(ggc_pkg::OP_ADD_NEIGHBOR, 6'd1, 6'd63);
    send_item(ggc_pkg::OP_ADD_NEIGHBOR, 6'd1, 6'd0);
    send_item(ggc_pkg::OP_COLOR, 6'd1, 6'd1);
    // graph clear keeps the colorings
    send_item(ggc_pkg::OP_CLEAR_GRAPH, 6'd63, 6'd63);
    send_item(ggc_pkg::OP_COLOR, 6'd0, 6'd0);
    send_item(ggc_pkg::OP_CLEAR_COLORS, 6'd63, 6'd0);
    send_item(ggc_pkg::OP_COLOR, 6'd63, 6'd63);
    send_item(ggc_pkg::OP_ADD_NEIGHBOR, 6'd42, 6'd21);
    send_item(ggc_pkg::OP_ADD_NEIGHBOR, 6'd21, 6'd42);
    send_item(ggc_pkg::OP_COLOR, 6'd21, 6'd42);
    send_item(ggc_pkg::OP_COLOR, 6'd42, 6'd21);
    send_item(ggc_pkg::OP_CLEAR_GRAPH, 6'd0, 6'd0);
    send_item(ggc_pkg::OP_CLEAR_COLORS, 6'd0, 6'd0);
  endtask

  // Build a small graph among a random group, then color it in random order.
  task automatic run_episode();
    logic [ggc_pkg::VERT_W-1:0] group[12];
    logic [ggc_pkg::VERT_W-1:0] t;
    int                         n, density, i, j;
    n       = $urandom_range(12, 2);
    density = $urandom_range(90, 15);
    for (i = 0; i < n; i++) group[i] = rand_vertex();
    if ($urandom_range(1) == 0) send_item(ggc_pkg::OP_CLEAR_COLORS, rand_vertex(), rand_vertex());
    for (i = 0; i < n; i++) begin
      for (j = i; j < n; j++) begin
        if ($urandom_range(99) < density) begin
          if (i == j) begin
            if ($urandom_range(9) == 0) send_item(ggc_pkg::OP_ADD_NEIGHBOR, group[i], group[i]);
          end else begin
            send_item(ggc_pkg::OP_ADD_NEIGHBOR, group[i], group[j]);
            if ($urandom_range(9) != 0) send_item(ggc_pkg::OP_ADD_NEIGHBOR, group[j], group[i]);
          end
        end
      end
    end
    for (i = n - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      t        = group[i];
      group[i] = group[j];
      group[j] = t;
    end
    for (i = 0; i < n; i++) send_item(ggc_pkg::OP_COLOR, group[i], rand_vertex());
    repeat ($urandom_range(3)) begin
      send_item(ggc_pkg::OP_COLOR, group[$urandom_range(n - 1)], rand_vertex());
    end
    if ($urandom_range(99) < 60) send_item(ggc_pkg::OP_CLEAR_GRAPH, rand_vertex(), rand_vertex());
  endtask

  task automatic run_random(input int count);
    logic [ggc_pkg::VERT_W-1:0] a, b;
    int                         stop_at, pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        run_episode();
      end else if (pick < 90) begin
        send_item(ggc_pkg::op_t'($urandom_range(3)), rand_vertex(), rand_vertex());
      end else begin
        // edges dropped before the coloring
        a = rand_vertex();
        b = rand_vertex();
        send_item(ggc_pkg::OP_ADD_NEIGHBOR, a, b);
        send_item(ggc_pkg::OP_ADD_NEIGHBOR, b, a);
        send_item(ggc_pkg::OP_CLEAR_GRAPH, rand_vertex(), rand_vertex());
        send_item(ggc_pkg::OP_COLOR, a, rand_vertex());
        send_item(ggc_pkg::OP_COLOR, b, rand_vertex());
      end
    end
  endtask

  // Vertex k of a random order lists the k before it, so it takes color k;
  // a self entry on the last one pushes it one color higher.
  task automatic run_color_ladder();
    logic [ggc_pkg::VERT_W-1:0] order[ggc_pkg::MAX_VERTICES];
    logic [ggc_pkg::VERT_W-1:0] t;
    int                         j, k;
    for (k = 0; k < ggc_pkg::MAX_VERTICES; k++) order[k] = ggc_pkg::VERT_W'(k);
    for (k = ggc_pkg::MAX_VERTICES - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    send_item(ggc_pkg::OP_CLEAR_GRAPH, rand_vertex(), rand_vertex());
    send_item(ggc_pkg::OP_CLEAR_COLORS, rand_vertex(), rand_vertex());
    for (k = 0; k < LADDER_LEN; k++) begin
      for (j = k - 1; j >= 0; j--) send_item(ggc_pkg::OP_ADD_NEIGHBOR, order[k], order[j]);
      send_item(ggc_pkg::OP_COLOR, order[k], rand_vertex());
    end
    send_item(ggc_pkg::OP_ADD_NEIGHBOR, order[LADDER_LEN - 1], order[LADDER_LEN - 1]);
    send_item(ggc_pkg::OP_COLOR, order[LADDER_LEN - 1], rand_vertex());
    send_item(ggc_pkg::OP_COLOR, order[0], rand_vertex());
    send_item(ggc_pkg::OP_CLEAR_COLORS, rand_vertex(), rand_vertex());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 21;
    recv_idle_pct <= 73;
    holds_asked   <= holds_asked + 1;
    run_directed();
    run_random(320);
    wait_drained();

    send_idle_pct = 73;
    recv_idle_pct <= 21;
    holds_asked   <= holds_asked + 1;
    run_random(320);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(320);
    run_color_ladder();
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
